// ===== design/mqps_pkg.sv =====
// ----------------------------------------------------------------------------
// mqps_pkg: shared constants for the multi-queue priority scheduler
// Queue geometry, opcodes and result status codes.
// ----------------------------------------------------------------------------
package mqps_pkg;

  localparam int QUEUES   = 3;
  localparam int CAPACITY = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int QIDX_W   = 2;
  localparam int FILL_W   = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(QUEUES * CAPACITY);
  localparam int PRIO_W   = 8;
  localparam int NUM_W    = 16;
  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_SERVED = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef logic [PRIO_W+NUM_W-1:0] slot_t;

endpackage

// ===== design/multi_queue_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// multi_queue_priority_scheduler
// Several priority queues in one slot memory; pop scans the queue for the
// highest priority, earliest arrival, and fills the hole with the last entry.
// ----------------------------------------------------------------------------
// Push, clear and rejected or empty ops are accepted in the idle state and the
// result (if any) sits in an output register. A pop that finds entries reads
// the queue's slots one per cycle from the single slot memory, then rereads the
// last slot and writes it into the hole; in_stall holds off new input until
// the pop has reported. Storage needs no clearing pass: the per-queue fill
// counts mark which slots hold data.
module multi_queue_priority_scheduler
  import mqps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [1:0]        in_queue_index,
  input  logic [7:0]        in_priority_req,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [15:0]       out_entry_number
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;

  slot_t             mem [QUEUES*CAPACITY];
  logic [FILL_W-1:0] fill_r [QUEUES];
  logic [NUM_W-1:0]  cnt_r;
  logic [2:0]        state_r;
  logic [QIDX_W-1:0] q_r;
  logic [FILL_W-1:0] rd_i_r;   // next slot to issue
  logic [SLOT_W-1:0] cmp_i_r;  // slot of data arriving this cycle
  logic              rd_v_r;
  logic              have_r;
  logic [PRIO_W-1:0] bp_r;
  logic [NUM_W-1:0]  bn_r;
  logic [SLOT_W-1:0] bi_r;
  slot_t             rdata_r;
  logic              ov_r;
  logic [1:0]        os_r;
  logic [NUM_W-1:0]  on_r;

  logic              acc, qok, out_free;
  logic [FILL_W-1:0] cur_fill;
  logic [ADDR_W-1:0] base, rd_addr;
  logic              better;
  logic [PRIO_W-1:0] rp;
  logic [NUM_W-1:0]  rn;

  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign acc      = in_valid && !in_stall;
  assign qok      = in_queue_index < QIDX_W'(QUEUES);
  assign cur_fill = qok ? fill_r[in_queue_index] : '0;

  assign base    = ADDR_W'(q_r) * ADDR_W'(CAPACITY);
  assign rd_addr = (state_r == S_LAST) ? base + ADDR_W'(fill_r[q_r] - 1'b1)
                                       : base + ADDR_W'(rd_i_r);
  assign rp      = rdata_r[PRIO_W+NUM_W-1:NUM_W];
  assign rn      = rdata_r[NUM_W-1:0];
  assign better  = !have_r || (rp > bp_r) || (rp == bp_r && rn < bn_r);

  // slot memory: one read or write per cycle
  always_ff @(posedge clk) begin
    if (acc && in_op == OP_PUSH && qok && cur_fill < FILL_W'(CAPACITY) &&
        cnt_r != NUM_MAX) begin
      mem[ADDR_W'(in_queue_index) * ADDR_W'(CAPACITY) + ADDR_W'(cur_fill)] <=
        {in_priority_req, cnt_r + 1'b1};
    end else if (state_r == S_FIX) begin
      mem[base + ADDR_W'(bi_r)] <= rdata_r;
    end else begin
      rdata_r <= mem[rd_addr];
    end
  end

  // control, scan and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      rd_v_r  <= 1'b0;
      for (int k = 0; k < QUEUES; k++) fill_r[k] <= '0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            unique case (in_op)
              OP_CLEAR: begin
                cnt_r <= '0;
                for (int k = 0; k < QUEUES; k++) fill_r[k] <= '0;
              end
              OP_PUSH: begin
                if (qok && cur_fill < FILL_W'(CAPACITY) && cnt_r != NUM_MAX) begin
                  cnt_r <= cnt_r + 1'b1;
                  fill_r[in_queue_index] <= cur_fill + 1'b1;
                end else begin
                  ov_r <= 1'b1; os_r <= ST_REJECT; on_r <= '0;
                end
              end
              OP_POP: begin
                if (cur_fill == '0) begin
                  ov_r <= 1'b1; os_r <= ST_EMPTY; on_r <= '0;
                end else begin
                  state_r <= S_SCAN;
                  q_r     <= in_queue_index;
                  rd_i_r  <= '0;
                  rd_v_r  <= 1'b0;
                  have_r  <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          // compare data issued last cycle
          if (rd_v_r && better) begin
            have_r <= 1'b1; bp_r <= rp; bn_r <= rn; bi_r <= cmp_i_r;
          end
          if (rd_i_r < fill_r[q_r]) begin
            cmp_i_r <= SLOT_W'(rd_i_r);
            rd_i_r  <= rd_i_r + 1'b1;
            rd_v_r  <= 1'b1;
          end else begin
            rd_v_r  <= 1'b0;
            state_r <= S_LAST;  // last slot is read next cycle
          end
        end
        S_LAST: begin
          state_r <= S_FIX;
        end
        default: begin  // S_FIX: move last entry into hole, report
          fill_r[q_r] <= fill_r[q_r] - 1'b1;
          ov_r <= 1'b1; os_r <= ST_SERVED; on_r <= bn_r;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = ov_r;
  assign out_status       = os_r;
  assign out_entry_number = on_r;

endmodule
